// ===== rtl/ptfl_pkg.sv =====
// Package: payload types, fixed-point constants and elaboration-time tables.
`default_nettype none
package ptfl_pkg;

   // Log table size and index width
   localparam int LOG_TABLE_ENTRIES = 256;
   localparam int LOG_BITS = $clog2(LOG_TABLE_ENTRIES);

   // Fixed-point constants
   localparam logic [16:0] TROPOPAUSE_PA = 17'd22632;
   localparam logic signed [14:0] EXPO_Q16 = 15'sd12467;
   localparam logic signed [24:0] STRAT_SCALE_Q16 = 25'sd9449533;
   localparam logic signed [27:0] TROPO_SCALE_Q16 = 28'sd95316972;
   localparam logic signed [31:0] TROPOPAUSE_HFT_Q16 = 32'sd23651444;
   localparam logic [16:0] FL_MAX_MAG = 17'd2500;
   localparam logic [16:0] FL_MIN_MAG = 17'd100;
   localparam logic signed [12:0] FL_MAX = 13'sd2500;
   localparam logic signed [12:0] FL_MIN = -13'sd100;
   localparam logic [30:0] EXP_ONE = 31'h4000_0000;
   localparam logic [15:0] DIV5_RECIP = 16'd52429;

   // Transaction payloads
   typedef struct packed {
      logic [16:0] pressure_pa;
      logic        pressure_missing;
   } req_type;

   typedef struct packed {
      logic signed [12:0] flight_level;
      logic               result_missing;
      logic               saturated;
   } rsp_type;

   // Control that travels with each item down the pipe
   typedef struct packed {
      logic valid;
      logic missing;
      logic zero;
      logic strat;
   } side_type;

   // Data carried alongside the exp2 chain
   typedef struct packed {
      logic signed [7:0]  n;
      logic signed [31:0] hs;
   } carry_type;

   typedef logic [16:0] rom_word_type;
   typedef rom_word_type rom_type [0:LOG_TABLE_ENTRIES];
   typedef logic [30:0] root_type [1:16];

   // log2(1+i/N) in Q16 by bit-serial squaring
   function automatic rom_word_type log_rom_entry(int unsigned i);
      logic [63:0] y;
      logic [16:0] r;
      r = '0;
      if (i >= LOG_TABLE_ENTRIES) begin
         return 17'd65536;
      end
      y = ((64'(LOG_TABLE_ENTRIES) + 64'(i)) << 30) / 64'(LOG_TABLE_ENTRIES);
      for (int b = 15; b >= 0; b--) begin
         y = (y * y) >> 30;
         if (y >= (64'd1 << 31)) begin
            y = y >> 1;
            r[b] = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic rom_type build_log_rom();
      rom_type t;
      for (int i = 0; i <= LOG_TABLE_ENTRIES; i++) begin
         t[i] = log_rom_entry(i);
      end
      return t;
   endfunction

   localparam rom_type LOG_ROM = build_log_rom();

   // log2 of a constant pressure, Q16
   function automatic logic [20:0] log2_const(int unsigned p);
      int unsigned e;
      logic [63:0] f;
      logic [63:0] pos;
      logic [63:0] w;
      logic [63:0] t0;
      logic [63:0] t1;
      int unsigned i;
      e = 0;
      for (int k = 0; k < 16; k++) begin
         if ((p >> (e + 1)) != 0) e++;
      end
      f = (64'(p) << (16 - e)) - 64'd65536;
      pos = f * 64'(LOG_TABLE_ENTRIES);
      i = 32'(pos >> 16);
      w = pos & 64'hFFFF;
      t0 = 64'(log_rom_entry(i));
      t1 = 64'(log_rom_entry(i + 1));
      return 21'((64'(e) << 16) + t0 + (((t1 - t0) * w) >> 16));
   endfunction

   localparam logic [20:0] LOG2_GROUND = log2_const(101325);
   localparam logic [20:0] LOG2_TROPO = log2_const(22632);

   // Integer square root for the root table
   function automatic logic [63:0] isqrt64(logic [63:0] xin);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bitv;
      x = xin;
      res = '0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // 2^(2^-j) in Q30, each the square root of the one before
   function automatic root_type build_roots();
      root_type t;
      logic [63:0] root;
      root = 64'd1 << 31;
      for (int j = 1; j <= 16; j++) begin
         root = isqrt64(root << 30);
         t[j] = 31'(root);
      end
      return t;
   endfunction

   localparam root_type EXP_ROOT = build_roots();

endpackage
`default_nettype wire

// ===== rtl/ptfl_log2.sv =====
// Three-stage log2 of the pressure in Q16: normalize, table lookup, interpolate.
`default_nettype none
module ptfl_log2 (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire ptfl_pkg::side_type side_in,
   input  wire logic [16:0]       pressure,
   output ptfl_pkg::side_type      side_out,
   output logic [20:0]            log2_q16
);
   import ptfl_pkg::*;

   localparam int POS_W = 16 + LOG_BITS;

   side_type side1_ff, side2_ff, side3_ff;
   logic [4:0]  e1_ff, e2_ff;
   logic [15:0] f1_ff;
   logic [4:0]  e_in;
   logic [16:0] norm;
   logic [15:0] w2_ff;
   logic [16:0] t0_ff, t1_ff;
   logic [POS_W-1:0] pos;
   logic [LOG_BITS:0] idx0, idx1;
   logic [16:0] slope;
   logic [32:0] interp;
   logic [20:0] lp_in, lp_ff;

   // Leading one search
   always_comb begin
      e_in = '0;
      for (int k = 1; k <= 16; k++) begin
         if (pressure[k]) e_in = 5'(k);
      end
   end

   assign norm = 17'(pressure << (5'd16 - e_in));

   // Table index and weight
   assign pos  = POS_W'(f1_ff) * POS_W'(LOG_TABLE_ENTRIES);
   assign idx0 = {1'b0, pos[POS_W-1:16]};
   assign idx1 = idx0 + 1'b1;

   // Linear interpolation
   assign slope  = t1_ff - t0_ff;
   assign interp = slope * w2_ff;
   assign lp_in  = {e2_ff, 16'b0} + 21'(t0_ff) + 21'(interp[32:16]);

   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff <= '0;
         side2_ff <= '0;
         side3_ff <= '0;
      end else if (enable) begin
         side1_ff <= side_in;
         side2_ff <= side1_ff;
         side3_ff <= side2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         e1_ff <= e_in;
         f1_ff <= norm[15:0];
         e2_ff <= e1_ff;
         w2_ff <= pos[15:0];
         t0_ff <= LOG_ROM[idx0];
         t1_ff <= LOG_ROM[idx1];
         lp_ff <= lp_in;
      end
   end

   assign side_out = side3_ff;
   assign log2_q16 = lp_ff;
endmodule
`default_nettype wire

// ===== rtl/ptfl_exp2.sv =====
// Sixteen-stage 2^frac product in Q30, one root factor per stage.
`default_nettype none
module ptfl_exp2 (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                enable,
   input  wire ptfl_pkg::side_type  side_in,
   input  wire logic [15:0]         frac,
   input  wire ptfl_pkg::carry_type carry_in,
   output ptfl_pkg::side_type       side_out,
   output logic [30:0]              acc_out,
   output ptfl_pkg::carry_type      carry_out
);
   import ptfl_pkg::*;

   side_type    side_ff  [1:16];
   logic [30:0] acc_ff   [1:16];
   logic [15:0] frac_ff  [1:16];
   carry_type   carry_ff [1:16];

   for (genvar j = 1; j <= 16; j++) begin : g_stage
      side_type    side_prev;
      logic [30:0] acc_prev;
      logic [15:0] frac_prev;
      carry_type   carry_prev;
      logic [61:0] prod;
      logic [30:0] acc_in;

      if (j == 1) begin : g_first
         assign side_prev  = side_in;
         assign acc_prev   = EXP_ONE;
         assign frac_prev  = frac;
         assign carry_prev = carry_in;
      end else begin : g_next
         assign side_prev  = side_ff[j-1];
         assign acc_prev   = acc_ff[j-1];
         assign frac_prev  = frac_ff[j-1];
         assign carry_prev = carry_ff[j-1];
      end

      // Multiply in this stage's root when its fraction bit is set
      assign prod   = acc_prev * EXP_ROOT[j];
      assign acc_in = frac_prev[16-j] ? prod[60:30] : acc_prev;

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[j] <= '0;
         end else if (enable) begin
            side_ff[j] <= side_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            acc_ff[j]   <= acc_in;
            frac_ff[j]  <= frac_prev;
            carry_ff[j] <= carry_prev;
         end
      end
   end

   assign side_out  = side_ff[16];
   assign acc_out   = acc_ff[16];
   assign carry_out = carry_ff[16];
endmodule
`default_nettype wire

// ===== rtl/pressure_to_flight_level.sv =====
// Top level: ISA pressure altitude to flight level pipeline.
// One pressure transaction is taken every cycle while the pipe is not stalled; the depth
// of the pipe is set by the 16-stage exp2 multiplier chain plus the log2 lookup,
// scaling and rounding stages. A stall on the result side freezes the whole pipe, and
// req_stall follows it in the same cycle. Levels are rounded to a multiple of 5 and
// clipped to -100..2500; zero pressure gives 2500 with saturated set, and a missing
// pressure gives level 0 with result_missing set.
`default_nettype none
module pressure_to_flight_level (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ptfl_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ptfl_pkg::rsp_type      rsp_data
);
   import ptfl_pkg::*;

   logic enable;
   logic rsp_valid_ff;

   // Pipe advances unless the output is held
   assign enable    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !enable;

   // Input register
   logic    in_valid_ff;
   req_type in_ff;
   side_type side0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (enable) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) in_ff <= req_data;
   end

   assign side0.valid   = in_valid_ff;
   assign side0.missing = in_ff.pressure_missing;
   assign side0.zero    = (in_ff.pressure_pa == '0);
   assign side0.strat   = (in_ff.pressure_pa <= TROPOPAUSE_PA);

   // log2 of pressure
   side_type    side3;
   logic [20:0] lp3;

   ptfl_log2 u_log2 (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .side_in  (side0),
      .pressure (in_ff.pressure_pa),
      .side_out (side3),
      .log2_q16 (lp3)
   );

   // Scale log differences
   side_type side4_ff;
   logic signed [21:0] d_t, d_s;
   logic signed [36:0] prod_t_ff;
   logic signed [46:0] prod_s_ff;

   assign d_t = $signed({1'b0, lp3}) - $signed({1'b0, LOG2_GROUND});
   assign d_s = $signed({1'b0, lp3}) - $signed({1'b0, LOG2_TROPO});

   // Round both products from Q32 to Q16, halves away from zero
   side_type side5_ff;
   logic [36:0] mag_t;
   logic [21:0] q_t;
   logic signed [23:0] z;
   logic [46:0] mag_s;
   logic [31:0] q_s;
   logic signed [31:0] hs_in;
   logic [15:0] frac5_ff;
   carry_type carry5_ff;

   assign mag_t = prod_t_ff[36] ? 37'(-prod_t_ff) : 37'(prod_t_ff);
   assign q_t   = 22'((mag_t + 37'd32768) >> 16);
   assign z     = prod_t_ff[36] ? -$signed({2'b0, q_t}) : $signed({2'b0, q_t});
   assign mag_s = prod_s_ff[46] ? 47'(-prod_s_ff) : 47'(prod_s_ff);
   assign q_s   = 32'((mag_s + 47'd32768) >> 16);
   assign hs_in = prod_s_ff[46] ? TROPOPAUSE_HFT_Q16 + $signed(q_s)
                                : TROPOPAUSE_HFT_Q16 - $signed(q_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         side4_ff <= '0;
         side5_ff <= '0;
      end else if (enable) begin
         side4_ff <= side3;
         side5_ff <= side4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_t_ff    <= EXPO_Q16 * d_t;
         prod_s_ff    <= STRAT_SCALE_Q16 * d_s;
         frac5_ff     <= z[15:0];
         carry5_ff.n  <= z[23:16];
         carry5_ff.hs <= hs_in;
      end
   end

   // 2^frac(z)
   side_type    side_x;
   logic [30:0] acc_x;
   carry_type   carry_x;

   ptfl_exp2 u_exp2 (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .side_in   (side5_ff),
      .frac      (frac5_ff),
      .carry_in  (carry5_ff),
      .side_out  (side_x),
      .acc_out   (acc_x),
      .carry_out (carry_x)
   );

   // Shift by floor(z) and form 1 - r
   side_type side22_ff;
   logic [7:0]  sh;
   logic [32:0] r;
   logic signed [33:0] diff_ff;
   logic signed [31:0] hs22_ff;

   assign sh = 8'(-carry_x.n);

   always_comb begin
      if (carry_x.n < 0) begin
         r = (sh > 8'd31) ? '0 : ({2'b0, acc_x} >> sh[4:0]);
      end else if (carry_x.n == 8'sd0) begin
         r = {2'b0, acc_x};
      end else if (carry_x.n == 8'sd1) begin
         r = {1'b0, acc_x, 1'b0};
      end else begin
         r = {acc_x, 2'b0};
      end
   end

   // Troposphere product
   side_type side23_ff;
   logic signed [61:0] prod_h_ff;
   logic signed [31:0] hs23_ff;

   // Round troposphere height and pick the layer
   side_type side24_ff;
   logic [61:0] mag_h;
   logic [31:0] q_h;
   logic signed [31:0] h_t;
   logic signed [31:0] h_ff;

   assign mag_h = prod_h_ff[61] ? 62'(-prod_h_ff) : 62'(prod_h_ff);
   assign q_h   = 32'((mag_h + 62'h2000_0000) >> 30);
   assign h_t   = prod_h_ff[61] ? -$signed(q_h) : $signed(q_h);

   // Divide magnitude by 5*2^16 with rounding
   side_type side25_ff;
   logic [32:0] mag_l;
   logic [16:0] x;
   logic [15:0] x16;
   logic [31:0] q_prod;
   logic [13:0] q25_ff;
   logic        neg25_ff;

   assign mag_l  = (h_ff[31] ? 33'(-{h_ff[31], h_ff}) : {1'b0, h_ff}) + 33'd163840;
   assign x      = mag_l[32:16];
   assign x16    = x[16] ? 16'hFFFF : x[15:0];
   assign q_prod = x16 * DIV5_RECIP;

   always_ff @(posedge clock) begin
      if (reset) begin
         side22_ff <= '0;
         side23_ff <= '0;
         side24_ff <= '0;
         side25_ff <= '0;
      end else if (enable) begin
         side22_ff <= side_x;
         side23_ff <= side22_ff;
         side24_ff <= side23_ff;
         side25_ff <= side24_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         diff_ff   <= 34'sh4000_0000 - $signed({1'b0, r});
         hs22_ff   <= carry_x.hs;
         prod_h_ff <= diff_ff * TROPO_SCALE_Q16;
         hs23_ff   <= hs22_ff;
         h_ff      <= side23_ff.strat ? hs23_ff : h_t;
         q25_ff    <= q_prod[31:18];
         neg25_ff  <= h_ff[31];
      end
   end

   // Final level, special cases and clipping
   logic [16:0] fl5;
   rsp_type     rsp_in;
   rsp_type     rsp_data_ff;

   assign fl5 = 17'(q25_ff) * 17'd5;

   always_comb begin
      rsp_in.result_missing = 1'b0;
      rsp_in.saturated      = 1'b0;
      rsp_in.flight_level   = '0;
      if (side25_ff.missing) begin
         rsp_in.result_missing = 1'b1;
      end else if (side25_ff.zero) begin
         rsp_in.flight_level = FL_MAX;
         rsp_in.saturated    = 1'b1;
      end else if (neg25_ff) begin
         if (fl5 > FL_MIN_MAG) begin
            rsp_in.flight_level = FL_MIN;
            rsp_in.saturated    = 1'b1;
         end else begin
            rsp_in.flight_level = -$signed(fl5[12:0]);
         end
      end else begin
         if (fl5 > FL_MAX_MAG) begin
            rsp_in.flight_level = FL_MAX;
            rsp_in.saturated    = 1'b1;
         end else begin
            rsp_in.flight_level = $signed(fl5[12:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= side25_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule
`default_nettype wire

// ===== sim/pressure_to_flight_level_test.sv =====
// Testbench: pressure_to_flight_level checked against a fixed-point flight level predictor.
`timescale 1ns / 1ps
module pressure_to_flight_level_test;
   import ptfl_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   req_type pending_pressures[$];
   rsp_type expected_levels[$];
   int      error_count = 0;
   int      accepted_count = 0;
   int      sender_idle_pct = 0;
   int      receiver_idle_pct = 0;

   pressure_to_flight_level uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Clock and reset
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------- Predictor ----------------
   localparam int NUM_ENTRIES = LOG_TABLE_ENTRIES;

   // log2(1 + i/N) in Q16, truncated, by repeated squaring
   function automatic longint log_entry(longint i);
      bit [63:0] y;
      longint    r;
      r = 0;
      if (i >= NUM_ENTRIES) return 65536;
      y = ((64'(NUM_ENTRIES) + 64'(i)) << 30) / 64'(NUM_ENTRIES);
      for (int b = 15; b >= 0; b--) begin
         y = (y * y) >> 30;
         if (y >= (64'd1 << 31)) begin
            y = y >> 1;
            r = r | (longint'(1) << b);
         end
      end
      return r;
   endfunction

   // log2 of a pressure in Q16, table lookup with linear interpolation
   function automatic longint log2_pressure(longint p);
      longint    e;
      bit [63:0] f;
      bit [63:0] pos;
      longint    idx;
      longint    w;
      longint    t0;
      longint    t1;
      e = 0;
      while (e < 16 && (p >> (e + 1)) != 0) e++;
      f = (64'(p) << (16 - e)) - 64'd65536;
      pos = f * 64'(NUM_ENTRIES);
      idx = longint'(pos >> 16);
      w = longint'(pos & 64'hFFFF);
      t0 = log_entry(idx);
      t1 = log_entry(idx + 1);
      return (e << 16) + t0 + (((t1 - t0) * w) >> 16);
   endfunction

   function automatic bit [63:0] int_sqrt(bit [63:0] x);
      bit [63:0] res;
      bit [63:0] probe;
      res = 0;
      probe = 64'd1 << 62;
      while (probe > x) probe = probe >> 2;
      while (probe != 0) begin
         if (x >= res + probe) begin
            x = x - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      return res;
   endfunction

   // 2^(fr/65536) in Q30 as a product of successive square roots of 2
   function automatic bit [63:0] pow2_fraction(longint fr);
      bit [63:0] acc;
      bit [63:0] root;
      acc = 64'd1 << 30;
      root = 64'd1 << 31;
      for (int j = 1; j <= 16; j++) begin
         root = int_sqrt(root << 30);
         if ((fr >> (16 - j)) & 1) acc = (acc * root) >> 30;
      end
      return acc;
   endfunction

   // Division with halves away from zero
   function automatic longint div_round(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic rsp_type predict_flight_level(req_type item);
      rsp_type   res;
      longint    p;
      longint    lp;
      longint    d;
      longint    z;
      longint    n;
      longint    h;
      longint    fl;
      bit [63:0] r;
      res = '0;
      p = longint'(item.pressure_pa);
      if (item.pressure_missing) begin
         res.result_missing = 1'b1;
         return res;
      end
      if (p == 0) begin
         fl = 2500;
         res.saturated = 1'b1;
      end else begin
         lp = log2_pressure(p);
         if (p > 22632) begin
            // Troposphere: power law through log2 and exp2
            d = lp - log2_pressure(101325);
            z = div_round(12467 * d, 65536);
            n = (z >= 0) ? (z >>> 16) : -((-z + 65535) >>> 16);
            r = pow2_fraction(z - n * 65536);
            if (n > 0) r = r << ((n > 2) ? 2 : n);
            else if (n < 0) r = (n < -40) ? 64'd0 : (r >> (-n));
            h = ((longint'(1) << 30) - longint'(r)) * 95316972;
            h = div_round(h, longint'(1) << 30);
         end else begin
            // Isothermal layer above the tropopause
            d = lp - log2_pressure(22632);
            h = 23651444 - div_round(9449533 * d, 65536);
         end
         fl = div_round(h, 5 * 65536) * 5;
         if (fl > 2500) begin
            fl = 2500;
            res.saturated = 1'b1;
         end else if (fl < -100) begin
            fl = -100;
            res.saturated = 1'b1;
         end
      end
      res.flight_level = 13'(fl);
      return res;
   endfunction

   // ---------------- Driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_levels.push_back(predict_flight_level(req_data));
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_pressures.size() != 0 &&
                $urandom_range(99, 0) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_pressures.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99, 0) < receiver_idle_pct);
   end

   // ---------------- Monitor ----------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_levels.size() == 0) begin
            $display("%0t: unexpected transaction, actual %p", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_levels.pop_front();
            if (rsp_data.flight_level !== want.flight_level) begin
               $display("%0t: flight_level expected %0d actual %0d", $time,
                        want.flight_level, rsp_data.flight_level);
               error_count++;
            end
            if (rsp_data.result_missing !== want.result_missing) begin
               $display("%0t: result_missing expected %b actual %b", $time,
                        want.result_missing, rsp_data.result_missing);
               error_count++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $display("%0t: saturated expected %b actual %b", $time,
                        want.saturated, rsp_data.saturated);
               error_count++;
            end
         end
      end
   end

   // Idle mix changes with progress through the random part
   always @(posedge clock) begin
      if (accepted_count < 300) begin
         sender_idle_pct <= 14;
         receiver_idle_pct <= 55;
      end else if (accepted_count < 580) begin
         sender_idle_pct <= 55;
         receiver_idle_pct <= 14;
      end else begin
         sender_idle_pct <= 0;
         receiver_idle_pct <= 0;
      end
   end

   function automatic req_type make_pressure(int unsigned pa, bit missing);
      req_type item;
      item.pressure_pa = 17'(pa);
      item.pressure_missing = missing;
      return item;
   endfunction

   // ---------------- Stimulus ----------------
   initial begin
      int unsigned pick;
      int unsigned pa;
      @(negedge reset);

      // Directed: extremes, layer boundary, missing and saturation cases
      pending_pressures.push_back(make_pressure(0, 1'b0));
      pending_pressures.push_back(make_pressure(1, 1'b0));
      pending_pressures.push_back(make_pressure(2, 1'b0));
      pending_pressures.push_back(make_pressure(131071, 1'b0));
      pending_pressures.push_back(make_pressure(101325, 1'b0));
      pending_pressures.push_back(make_pressure(22632, 1'b0));
      pending_pressures.push_back(make_pressure(22631, 1'b0));
      pending_pressures.push_back(make_pressure(22633, 1'b0));
      pending_pressures.push_back(make_pressure(120000, 1'b0));
      pending_pressures.push_back(make_pressure(65536, 1'b0));
      pending_pressures.push_back(make_pressure(1000, 1'b0));
      pending_pressures.push_back(make_pressure(5000, 1'b0));
      pending_pressures.push_back(make_pressure(250, 1'b0));
      pending_pressures.push_back(make_pressure(0, 1'b1));
      pending_pressures.push_back(make_pressure(131071, 1'b1));
      pending_pressures.push_back(make_pressure(50000, 1'b1));

      // Sender holds off until the pipe has drained
      wait (pending_pressures.size() == 0 && !req_valid && expected_levels.size() == 0);

      for (int k = 0; k < 800; k++) begin
         pick = $urandom_range(9, 0);
         case (pick)
            0: pa = $urandom_range(131071, 0);
            1: pa = $urandom_range(131071, 0);
            2: pa = $urandom_range(22672, 22592);
            3: pa = $urandom_range(400, 0);
            default: pa = $urandom_range(110000, 1000);
         endcase
         pending_pressures.push_back(make_pressure(pa, $urandom_range(11, 0) == 0));
      end

      wait (pending_pressures.size() == 0 && !req_valid && expected_levels.size() == 0);
      repeat (60) @(posedge clock);
      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   // Timeout
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== pressure_to_flight_level.f =====
rtl/ptfl_pkg.sv
rtl/ptfl_log2.sv
rtl/ptfl_exp2.sv
rtl/pressure_to_flight_level.sv
sim/pressure_to_flight_level_test.sv
